/* rtl/assert_macros.svh */
// Shared concurrent assertion helpers; each assumes clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IOL_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define IOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/iol_pkg.sv */
package iol_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  // wide enough to compare a position against the count without wrap
  localparam int unsigned CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_READ       = 3'd6
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // apply the captured command to the list
  } ctrl_cmd_t;

endpackage

/* rtl/iol_ctrl.sv */
`include "assert_macros.svh"

module iol_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output iol_pkg::ctrl_cmd_t  cmd_o
);
  import iol_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_q == S_EXEC);
  assign done_o     = done_q;
  assign cmd_o.load = start && !busy;
  assign cmd_o.exec = (state_q == S_EXEC);

  `IOL_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `IOL_ASSERT_NEXT(a_exec_then_done, state_q == S_EXEC, done_o && !busy)
  `IOL_ASSERT(a_done_after_exec_only, done_o, $past(state_q) == S_EXEC)

endmodule

/* rtl/iol_dp.sv */
`include "assert_macros.svh"

module iol_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  iol_pkg::ctrl_cmd_t              cmd_i,
  input  logic [iol_pkg::CMD_W-1:0]       cmd_word_i,
  input  logic [iol_pkg::POS_W-1:0]       position_i,
  input  logic signed [iol_pkg::VAL_W-1:0] item_value_i,
  output logic signed [iol_pkg::VAL_W-1:0] read_value_o,
  output logic [iol_pkg::CNT_W-1:0]       entry_count_o,
  output logic [iol_pkg::ST_W-1:0]        status_o
);
  import iol_pkg::*;

  logic [CMD_W-1:0]      op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [DATA_WIDTH-1:0] entries_q [DEPTH];
  logic [DATA_WIDTH-1:0] entries_d [DEPTH];

  logic [CNT_W-1:0]      count_q, count_d;
  logic [VAL_W-1:0]      rd_q, rd_d;
  logic [ST_W-1:0]       st_q, st_d;

  logic                  do_ins, do_rem;
  logic [CNT_W-1:0]      slot;
  logic                  full, empty;
  logic [CMP_W-1:0]      pos_x, cnt_x;

  always_comb begin
    full   = (count_q == CNT_W'(DEPTH));
    empty  = (count_q == '0);
    pos_x  = CMP_W'(pos_q);
    cnt_x  = CMP_W'(count_q);
    do_ins = 1'b0;
    do_rem = 1'b0;
    slot   = '0;
    count_d = count_q;
    rd_d    = '0;
    st_d    = ST_OK;
    case (op_q)
      CMD_PUSH_FRONT: begin
        if (full) st_d = ST_FULL;
        else do_ins = 1'b1;
      end
      CMD_PUSH_BACK: begin
        if (full) st_d = ST_FULL;
        else begin
          do_ins = 1'b1;
          slot   = count_q;
        end
      end
      CMD_POP_FRONT: begin
        if (!empty) do_rem = 1'b1;
      end
      CMD_POP_BACK: begin
        if (empty) st_d = ST_INDEX;
        else count_d = count_q - CNT_W'(1);
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) st_d = ST_INDEX;
        else if (full) st_d = ST_FULL;
        else begin
          do_ins = 1'b1;
          slot   = CNT_W'(pos_q);
        end
      end
      CMD_REMOVE: begin
        if (pos_x >= cnt_x) st_d = ST_INDEX;
        else begin
          do_rem = 1'b1;
          slot   = CNT_W'(pos_q);
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) st_d = ST_INDEX;
        else rd_d = VAL_W'(entries_q[pos_q[IDX_W-1:0]]);
      end
      default: ;  // unused code: no change, status ok
    endcase
    if (do_ins) count_d = count_q + CNT_W'(1);
    if (do_rem) count_d = count_q - CNT_W'(1);
  end

  // Each cell picks from itself, its neighbor below or above, or the new word.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins) begin
        if (CNT_W'(i) == slot) entries_d[i] = val_q;
        else if (i > 0 && CNT_W'(i) > slot) entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else if (do_rem) begin
        if (i < DEPTH - 1 && CNT_W'(i) >= slot) entries_d[i] = entries_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= cmd_word_i;
      pos_q <= position_i;
      val_q <= DATA_WIDTH'(item_value_i);
    end
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      rd_q      <= rd_d;
      st_q      <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign read_value_o  = rd_q;
  assign entry_count_o = count_q;
  assign status_o      = st_q;

  `IOL_ASSERT_NEXT(a_count_holds_when_idle, !cmd_i.exec, $stable(count_q))
  `IOL_ASSERT(a_count_bounded, 1'b1, count_q <= CNT_W'(DEPTH))
  `IOL_ASSERT(a_single_edit, cmd_i.exec, !(do_ins && do_rem))

endmodule

/* rtl/indexed_ordered_list.sv */
// Channel   Handshake        Ports
// --------  ---------------  ------------------------------------------
// command   start / busy     cmd_i, position_i, item_value_i
// result    done_o strobe    read_value_o, entry_count_o, status_o
//
// A command is taken at the accept edge, then runs in the execute state, in which
// inserts and front or indexed removals shift the entry chain up or down around the index in a single step.
// done_o is high for the cycle after execute; a new start is taken that cycle.
// Reset clears the entry count and control; entry storage is not cleared.
// The receiver cannot stall; results are never held back.
module indexed_ordered_list (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [iol_pkg::CMD_W-1:0]        cmd_i,
  input  logic [iol_pkg::POS_W-1:0]        position_i,
  input  logic signed [iol_pkg::VAL_W-1:0] item_value_i,
  output logic                             done_o,
  output logic signed [iol_pkg::VAL_W-1:0] read_value_o,
  output logic [iol_pkg::CNT_W-1:0]        entry_count_o,
  output logic [iol_pkg::ST_W-1:0]         status_o
);
  import iol_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  iol_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (ctrl_cmd)
  );

  iol_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .cmd_word_i    (cmd_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule
